FILE: hdl/ndnz_pkg.sv
package ndnz_pkg;

   // Configuration register indexes.
   localparam logic CSR_ROW_COUNT = 1'b0;
   localparam logic CSR_COL_COUNT = 1'b1;

   // Field widths fixed by the interface.
   localparam int unsigned SIZE_W  = 16;
   localparam int unsigned ELEM_W  = 8;
   localparam int unsigned DEST_W  = 32;

   // Register values after reset.
   localparam logic [SIZE_W-1:0] ROW_COUNT_RST = 16'd16;
   localparam logic [SIZE_W-1:0] COL_COUNT_RST = 16'd32;

   // Width that holds any in-matrix offset and any matrix stride for all
   // legal tile and block sizes.
   localparam int unsigned OFF_W = 34;

endpackage

FILE: hdl/nd_to_fractal_nz_address_gen.sv
// Timing: an accepted request's result is registered in the result register and shows
// on the rsp_ port in the cycle after the accept.
// Throughput: one request per cycle while the receiver keeps taking results.
// Reset (synchronous, active high) sets row_count to 16 and col_count to 32, clears
// all position counters, base addresses and the sticky overflow, and empties the
// result register.
module nd_to_fractal_nz_address_gen #(
   parameter int unsigned TILE_COLS  = 32,
   parameter int unsigned BLOCK_ROWS = 16,
   parameter int unsigned ADDR_BITS  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ndnz_pkg::ELEM_W-1:0]       req_elem_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ndnz_pkg::DEST_W-1:0]       rsp_dest_addr,
   output logic [ndnz_pkg::ELEM_W-1:0]       rsp_elem_out,
   output logic                              rsp_addr_overflow,
   input  logic                              csr_we,
   input  logic                              csr_index,
   input  logic [ndnz_pkg::SIZE_W-1:0]       csr_wdata
);

   // Widths of the position counters and address arithmetic.
   localparam int unsigned CIT_W  = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
   localparam int unsigned ROW_W  = ndnz_pkg::SIZE_W + $clog2(TILE_COLS);
   localparam int unsigned OFF_W  = ndnz_pkg::OFF_W;
   localparam int unsigned FULL_W = ((ADDR_BITS > OFF_W) ? ADDR_BITS : OFF_W) + 1;

   // The number of row blocks, ceil(k / BLOCK_ROWS), is found at the time
   // row_count is written, by a multiplication with a fixed-point reciprocal.
   // The numerator k + BLOCK_ROWS - 1 fits in NUM_W bits, and a shift of
   // NUM_W + ceil(log2(BLOCK_ROWS)) makes the quotient exact for all of them.
   localparam int unsigned NUM_W  = ndnz_pkg::SIZE_W + 1;
   localparam int unsigned RCP_W  = NUM_W + 2;
   localparam int unsigned PROD_W = NUM_W + RCP_W;
   localparam int unsigned RCP_SH = NUM_W + $clog2(BLOCK_ROWS);
   localparam logic [RCP_W-1:0] RCP_MUL =
      RCP_W'(((64'd1 << RCP_SH) + 64'(BLOCK_ROWS) - 64'd1) / 64'(BLOCK_ROWS));
   localparam logic [NUM_W-1:0] ROW_BLOCKS_RST =
      NUM_W'((ndnz_pkg::ROW_COUNT_RST + BLOCK_ROWS - 1) / BLOCK_ROWS);
   localparam logic [OFF_W-1:0] BLOCK_AREA = OFF_W'(BLOCK_ROWS * TILE_COLS);
   localparam logic [CIT_W:0]   TILE_COLS_C = (CIT_W + 1)'(TILE_COLS);
   localparam logic [ROW_W-1:0] ROW_STEP = ROW_W'(TILE_COLS);

   // Configuration registers and the derived row block count.
   logic [ndnz_pkg::SIZE_W-1:0] row_count_ff, row_count_in;
   logic [ndnz_pkg::SIZE_W-1:0] col_count_ff, col_count_in;
   logic [NUM_W-1:0]            row_blocks_ff, row_blocks_in;

   // Stream position state.
   logic [CIT_W-1:0]            col_in_tile_ff, col_in_tile_in;
   logic [ndnz_pkg::SIZE_W-1:0] col_pos_ff, col_pos_in;
   logic [ndnz_pkg::SIZE_W-1:0] row_pos_ff, row_pos_in;
   logic [OFF_W-1:0]            tile_base_ff, tile_base_in;
   logic [ROW_W-1:0]            row_base_ff, row_base_in;
   logic [ADDR_BITS-1:0]        batch_base_ff, batch_base_in;
   logic                        ovf_seen_ff, ovf_seen_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ndnz_pkg::DEST_W-1:0] rsp_dest_ff, rsp_dest_in;
   logic [ndnz_pkg::ELEM_W-1:0] rsp_elem_ff, rsp_elem_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic                        accept;
   logic [NUM_W-1:0]            size_eff;
   logic [NUM_W-1:0]            blk_num;
   logic [PROD_W-1:0]           blk_prod;
   logic [OFF_W-1:0]            tile_stride;
   logic [OFF_W-1:0]            offset;
   logic [FULL_W-1:0]           full_addr;
   logic                        addr_over;
   logic [63:0]                 addr_wide;
   logic [CIT_W:0]              cit_inc;
   logic                        tile_wrap;
   logic [CIT_W-1:0]            cit_after;
   logic [OFF_W-1:0]            tile_base_after;
   logic [ndnz_pkg::SIZE_W-1:0] col_pos_inc;
   logic [ndnz_pkg::SIZE_W-1:0] row_pos_inc;
   logic                        row_end;
   logic                        mat_end;
   logic [OFF_W-1:0]            row_span;
   logic [FULL_W-1:0]           next_batch;
   logic                        batch_over;

   // The result register frees up in the same cycle that its result is taken, so a
   // steady stream moves one request per cycle while the receiver keeps taking them.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // A size of zero stands for 65536, since the 16-bit counters wrap there.
   assign size_eff = {(csr_wdata == '0), csr_wdata};
   assign blk_num  = size_eff + NUM_W'(BLOCK_ROWS - 1);
   assign blk_prod = PROD_W'(blk_num) * PROD_W'(RCP_MUL);

   // Distance between two column tiles inside one matrix.
   assign tile_stride = OFF_W'(row_blocks_ff) * BLOCK_AREA;

   // Address of the current request. The sum is kept one bit wider than both
   // terms so that a wrap past the address width can be seen.
   assign offset    = tile_base_ff + OFF_W'(row_base_ff) + OFF_W'(col_in_tile_ff);
   assign full_addr = FULL_W'(batch_base_ff) + FULL_W'(offset);
   assign addr_over = ovf_seen_ff || ((full_addr >> ADDR_BITS) != '0);
   assign addr_wide = 64'(full_addr[ADDR_BITS-1:0]);

   // Column tile step.
   assign cit_inc         = {1'b0, col_in_tile_ff} + (CIT_W + 1)'(1);
   assign tile_wrap       = (cit_inc >= TILE_COLS_C);
   assign cit_after       = tile_wrap ? '0 : cit_inc[CIT_W-1:0];
   assign tile_base_after = tile_wrap ? (tile_base_ff + tile_stride) : tile_base_ff;

   // Row and matrix boundaries.
   assign col_pos_inc = col_pos_ff + 16'd1;
   assign row_pos_inc = row_pos_ff + 16'd1;
   assign row_end     = (col_pos_inc == col_count_ff);
   assign mat_end     = row_end && (row_pos_inc == row_count_ff);

   // At the end of a row the tile base has covered every full column tile; a
   // partly filled last tile still takes a whole tile of space. That span is the
   // matrix stride, found without a multiplier by the column tile count.
   assign row_span   = tile_base_after + ((cit_after != '0) ? tile_stride : '0);
   assign next_batch = FULL_W'(batch_base_ff) + FULL_W'(row_span);
   assign batch_over = ((next_batch >> ADDR_BITS) != '0);

   always_comb begin
      row_count_in   = row_count_ff;
      col_count_in   = col_count_ff;
      row_blocks_in  = row_blocks_ff;
      col_in_tile_in = col_in_tile_ff;
      col_pos_in     = col_pos_ff;
      row_pos_in     = row_pos_ff;
      tile_base_in   = tile_base_ff;
      row_base_in    = row_base_ff;
      batch_base_in  = batch_base_ff;
      ovf_seen_in    = ovf_seen_ff;

      if (csr_we) begin
         // A register write restarts the stream at address zero.
         unique case (csr_index)
            ndnz_pkg::CSR_ROW_COUNT: begin
               row_count_in  = csr_wdata;
               row_blocks_in = NUM_W'(blk_prod >> RCP_SH);
            end
            ndnz_pkg::CSR_COL_COUNT: begin
               col_count_in = csr_wdata;
            end
            default: begin
            end
         endcase
         col_in_tile_in = '0;
         col_pos_in     = '0;
         row_pos_in     = '0;
         tile_base_in   = '0;
         row_base_in    = '0;
         batch_base_in  = '0;
         ovf_seen_in    = 1'b0;
      end else if (accept) begin
         col_in_tile_in = cit_after;
         col_pos_in     = col_pos_inc;
         tile_base_in   = tile_base_after;
         if (row_end) begin
            col_in_tile_in = '0;
            col_pos_in     = '0;
            tile_base_in   = '0;
            if (mat_end) begin
               row_pos_in    = '0;
               row_base_in   = '0;
               batch_base_in = next_batch[ADDR_BITS-1:0];
               ovf_seen_in   = ovf_seen_ff || batch_over;
            end else begin
               row_pos_in  = row_pos_inc;
               row_base_in = row_base_ff + ROW_STEP;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_dest_in  = rsp_dest_ff;
      rsp_elem_in  = rsp_elem_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_dest_in  = addr_wide[ndnz_pkg::DEST_W-1:0];
         rsp_elem_in  = req_elem_value;
         rsp_ovf_in   = addr_over;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff   <= ndnz_pkg::ROW_COUNT_RST;
         col_count_ff   <= ndnz_pkg::COL_COUNT_RST;
         row_blocks_ff  <= ROW_BLOCKS_RST;
         col_in_tile_ff <= '0;
         col_pos_ff     <= '0;
         row_pos_ff     <= '0;
         tile_base_ff   <= '0;
         row_base_ff    <= '0;
         batch_base_ff  <= '0;
         ovf_seen_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         row_count_ff   <= row_count_in;
         col_count_ff   <= col_count_in;
         row_blocks_ff  <= row_blocks_in;
         col_in_tile_ff <= col_in_tile_in;
         col_pos_ff     <= col_pos_in;
         row_pos_ff     <= row_pos_in;
         tile_base_ff   <= tile_base_in;
         row_base_ff    <= row_base_in;
         batch_base_ff  <= batch_base_in;
         ovf_seen_ff    <= ovf_seen_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Result payload carries no reset.
   always_ff @(posedge clock) begin
      rsp_dest_ff <= rsp_dest_in;
      rsp_elem_ff <= rsp_elem_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dest_addr     = rsp_dest_ff;
   assign rsp_elem_out      = rsp_elem_ff;
   assign rsp_addr_overflow = rsp_ovf_ff;

endmodule

FILE: test/nz_placement_checker.sv
module nz_placement_checker #(
   parameter int unsigned TILE_COLS  = 32,
   parameter int unsigned BLOCK_ROWS = 16,
   parameter int unsigned ADDR_BITS  = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [ndnz_pkg::ELEM_W-1:0] req_elem_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [ndnz_pkg::DEST_W-1:0] rsp_dest_addr,
   input  logic [ndnz_pkg::ELEM_W-1:0] rsp_elem_out,
   input  logic                        rsp_addr_overflow,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [ndnz_pkg::SIZE_W-1:0] csr_wdata,
   output int unsigned                 placements_pending,
   output int unsigned                 failures
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SIZE_W      = ndnz_pkg::SIZE_W;
   localparam int unsigned ELEM_W      = ndnz_pkg::ELEM_W;
   localparam int unsigned DEST_W      = ndnz_pkg::DEST_W;
   localparam int unsigned MAX_REPORTS = 10;
   localparam logic [63:0] ADDR_MASK   = (64'd1 << ADDR_BITS) - 64'd1;

   typedef struct packed {
      logic [DEST_W-1:0] dest_addr;
      logic [ELEM_W-1:0] elem;
      logic              overflow;
   } nz_result_type;

   logic [SIZE_W-1:0] row_count;
   logic [SIZE_W-1:0] col_count;
   int unsigned       col_in_tile;
   logic [SIZE_W-1:0] col_pos;
   logic [SIZE_W-1:0] row_pos;
   logic [63:0]       tile_base;
   logic [63:0]       row_base;
   logic [63:0]       batch_base;
   logic              batch_wrapped;
   nz_result_type     expected_placements[$];

   // A size register of zero means 65536, as the 16-bit counters wrap there.
   function automatic logic [63:0] matrix_dim(input logic [SIZE_W-1:0] size);
      return (size == '0) ? 64'd65536 : 64'(size);
   endfunction

   // Distance between neighboring column tiles: the padded row count times the tile width.
   function automatic logic [63:0] tile_stride();
      return (matrix_dim(row_count) + BLOCK_ROWS - 1) / BLOCK_ROWS * BLOCK_ROWS * TILE_COLS;
   endfunction

   function automatic void clear_position();
      col_in_tile   = 0;
      col_pos       = '0;
      row_pos       = '0;
      tile_base     = '0;
      row_base      = '0;
      batch_base    = '0;
      batch_wrapped = 1'b0;
   endfunction

   function automatic nz_result_type place_element(input logic [ELEM_W-1:0] value);
      nz_result_type placed;
      logic [63:0]   full_addr;
      logic [63:0]   wrapped_addr;
      logic [63:0]   next_batch;
      full_addr        = batch_base + tile_base + row_base + 64'(col_in_tile);
      wrapped_addr     = full_addr & ADDR_MASK;
      placed.dest_addr = wrapped_addr[DEST_W-1:0];
      placed.elem      = value;
      placed.overflow  = batch_wrapped || (full_addr > ADDR_MASK);

      col_pos = col_pos + 1'b1;
      col_in_tile++;
      if (col_in_tile >= TILE_COLS) begin
         col_in_tile = 0;
         tile_base   = tile_base + tile_stride();
      end
      if (col_pos == col_count) begin
         col_pos     = '0;
         col_in_tile = 0;
         tile_base   = '0;
         row_pos     = row_pos + 1'b1;
         row_base    = row_base + TILE_COLS;
         if (row_pos == row_count) begin
            next_batch = batch_base + (matrix_dim(col_count) + TILE_COLS - 1) / TILE_COLS
                         * tile_stride();
            row_pos  = '0;
            row_base = '0;
            if (next_batch > ADDR_MASK) begin
               batch_wrapped = 1'b1;
            end
            batch_base = next_batch & ADDR_MASK;
         end
      end
      return placed;
   endfunction

   function automatic void report_failure(input string why, input nz_result_type want,
                                          input nz_result_type got);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("%t %s: expected addr=%h elem=%h ovf=%b, got addr=%h elem=%h ovf=%b",
                  $realtime, why, want.dest_addr, want.elem, want.overflow,
                  got.dest_addr, got.elem, got.overflow);
      end
   endfunction

   // Responses are checked before the same edge's request is predicted, so a
   // response can never be matched against a request accepted at its own edge.
   always @(posedge clock) begin
      nz_result_type got;
      nz_result_type want;
      if (reset) begin
         row_count = ndnz_pkg::ROW_COUNT_RST;
         col_count = ndnz_pkg::COL_COUNT_RST;
         clear_position();
         expected_placements.delete();
         failures = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.dest_addr = rsp_dest_addr;
            got.elem      = rsp_elem_out;
            got.overflow  = rsp_addr_overflow;
            if (expected_placements.size() == 0) begin
               report_failure("Response with no request outstanding", '0, got);
            end else begin
               want = expected_placements.pop_front();
               if (got !== want) begin
                  report_failure("Response mismatch", want, got);
               end
            end
         end
         if (csr_we) begin
            if (csr_index == ndnz_pkg::CSR_ROW_COUNT) begin
               row_count = csr_wdata;
            end else begin
               col_count = csr_wdata;
            end
            clear_position();
         end
         if (req_valid && req_ready) begin
            expected_placements.push_back(place_element(req_elem_value));
         end
      end
      placements_pending = expected_placements.size();
   end

endmodule

FILE: test/nd_to_fractal_nz_address_gen_tb.sv
module nd_to_fractal_nz_address_gen_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SIZE_W = ndnz_pkg::SIZE_W;
   localparam int unsigned ELEM_W = ndnz_pkg::ELEM_W;
   localparam int unsigned DEST_W = ndnz_pkg::DEST_W;

   // The block is run with the sizes it ships with.
   localparam int unsigned TILE_COLS  = 32;
   localparam int unsigned BLOCK_ROWS = 16;
   localparam int unsigned ADDR_BITS  = 32;

   // Number of random requests, the length of the receiver's long hold-off, and the
   // number of cycles without any handshake after which the run is declared hung.
   localparam int unsigned RANDOM_REQUESTS = 1550;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned WATCHDOG_LIMIT  = 3000;
   localparam int unsigned DEFAULT_IDLE    = 37;

   logic              clock          = 1'b0;
   logic              reset          = 1'b1;
   logic              req_valid      = 1'b0;
   logic              req_ready;
   logic [ELEM_W-1:0] req_elem_value = '0;
   logic              rsp_valid;
   logic              rsp_ready      = 1'b0;
   logic [DEST_W-1:0] rsp_dest_addr;
   logic [ELEM_W-1:0] rsp_elem_out;
   logic              rsp_addr_overflow;
   logic              csr_we         = 1'b0;
   logic              csr_index      = ndnz_pkg::CSR_ROW_COUNT;
   logic [SIZE_W-1:0] csr_wdata      = '0;

   int unsigned placements_pending;
   int unsigned failures;

   // Percentages of cycles in which each side sits idle, changed per phase by the
   // stimulus. A hold-off is requested by bumping holds_requested; the receiver
   // notices the change and counts the stall out on its own.
   int unsigned req_idle_pct    = DEFAULT_IDLE;
   int unsigned rsp_idle_pct    = DEFAULT_IDLE;
   int unsigned holds_requested = 0;
   int unsigned quiet_cycles    = 0;

   logic [ELEM_W-1:0] corner_values [6] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};

   nd_to_fractal_nz_address_gen #(
      .TILE_COLS  (TILE_COLS),
      .BLOCK_ROWS (BLOCK_ROWS),
      .ADDR_BITS  (ADDR_BITS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_elem_value    (req_elem_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_dest_addr     (rsp_dest_addr),
      .rsp_elem_out      (rsp_elem_out),
      .rsp_addr_overflow (rsp_addr_overflow),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   nz_placement_checker #(
      .TILE_COLS  (TILE_COLS),
      .BLOCK_ROWS (BLOCK_ROWS),
      .ADDR_BITS  (ADDR_BITS)
   ) i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_elem_value     (req_elem_value),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_dest_addr      (rsp_dest_addr),
      .rsp_elem_out       (rsp_elem_out),
      .rsp_addr_overflow  (rsp_addr_overflow),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .placements_pending (placements_pending),
      .failures           (failures)
   );

   // 4 ns clock, first rising edge at 2 ns.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is declared hung once no request, response or register write has
   // moved for a long time. The limit is well above the receiver's hold-off.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver makes exactly one decision per falling edge, so rsp_ready never
   // sees two assignments within one time step.
   initial begin : receiver
      int unsigned stall_left;
      int unsigned holds_done;
      stall_left = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (holds_done != holds_requested) begin
            holds_done = holds_requested;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // Offers one request, starting and ending at a falling edge. Valid is only
   // lowered when an idle gap comes before the request, so back-to-back requests
   // keep valid high instead of dropping and raising it in the same step.
   task automatic send_request(input logic [ELEM_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_elem_value <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Stops offering and waits until every response that was predicted has come back.
   // Every request yields a response, so the block is idle from then on.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (placements_pending != 0);
   endtask

   // One register write; the extra falling edge keeps two writes in a row from
   // lowering and raising the write enable in the same step.
   task automatic write_reg(input logic index, input logic [SIZE_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Mostly small sizes, so that whole matrices, row ends and tile crossings all
   // happen within one phase; now and then an extreme or a fully random size.
   function automatic logic [SIZE_W-1:0] pick_size(input int unsigned small_max);
      case ($urandom_range(11))
         0:       return '0;
         1:       return '1;
         2:       return SIZE_W'(1);
         3:       return SIZE_W'($urandom);
         default: return SIZE_W'($urandom_range(small_max, 1));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned sent;
      int unsigned burst;
      int unsigned phase;
      sent  = 0;
      phase = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. First the reset sizes of 16 rows by 32 columns, with the
      // extreme and alternating element values.
      foreach (corner_values[i]) begin
         send_request(corner_values[i]);
      end

      // One-by-one matrices: every element closes a whole matrix, so the batch
      // base moves on by one padded tile each time.
      wait_for_drain();
      write_reg(ndnz_pkg::CSR_ROW_COUNT, SIZE_W'(1));
      write_reg(ndnz_pkg::CSR_COL_COUNT, SIZE_W'(1));
      repeat (4) send_request(ELEM_W'($urandom_range(255)));

      // Zero sizes stand for 65536 rows and columns.
      wait_for_drain();
      write_reg(ndnz_pkg::CSR_ROW_COUNT, '0);
      write_reg(ndnz_pkg::CSR_COL_COUNT, '0);
      repeat (4) send_request(ELEM_W'($urandom_range(255)));

      // The largest sizes, one register at a time; each write also restarts the
      // stream at address zero.
      wait_for_drain();
      write_reg(ndnz_pkg::CSR_ROW_COUNT, '1);
      repeat (3) send_request(ELEM_W'($urandom_range(255)));
      wait_for_drain();
      write_reg(ndnz_pkg::CSR_COL_COUNT, '1);
      repeat (3) send_request(ELEM_W'($urandom_range(255)));

      // Random part, in phases. Each phase starts from an idle block with new sizes
      // in one or both registers, often in the middle of a matrix, which checks
      // that a write clears the position.
      while (sent < RANDOM_REQUESTS) begin
         phase++;
         wait_for_drain();
         case ($urandom_range(3))
            0: write_reg(ndnz_pkg::CSR_ROW_COUNT, pick_size(40));
            1: write_reg(ndnz_pkg::CSR_COL_COUNT, pick_size(70));
            default: begin
               write_reg(ndnz_pkg::CSR_ROW_COUNT, pick_size(40));
               write_reg(ndnz_pkg::CSR_COL_COUNT, pick_size(70));
            end
         endcase

         burst = $urandom_range(150, 20);
         if (phase % 7 == 3) begin
            // A long stretch at full rate on both sides.
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            burst        = 200;
         end else if (phase % 7 == 5) begin
            // The receiver holds off while the sender keeps offering, so the
            // block fills up and has to stall its input.
            holds_requested++;
         end

         repeat (burst) begin
            send_request(ELEM_W'($urandom_range(255)));
            sent++;
         end
         req_idle_pct = DEFAULT_IDLE;
         rsp_idle_pct = DEFAULT_IDLE;
      end

      // Let the last responses come back, then give the block a few more cycles
      // to show any response that was never asked for. Ending on a falling edge
      // lets the checker finish with the last rising edge first.
      wait_for_drain();
      repeat (4) @(negedge clock);

      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
